FILE: hdl/tsr_pkg.sv
`default_nettype none

package tsr_pkg;

  // Field widths fixed by the stream format.
  localparam int unsigned NodeW  = 10;
  localparam int unsigned CntW   = 11;
  localparam int unsigned ModeW  = 3;

  // Highest node count that the 10-bit node fields can address.
  localparam int unsigned NodeCap     = 1024;
  localparam int unsigned MaxNodesDef = 1024;

  localparam logic [CntW-1:0] NodeCountRst = 11'd1024;

  // Stream payload widths; the output width is rounded up to whole bytes.
  localparam int unsigned InDataW  = 4 * NodeW;
  localparam int unsigned OutRawW  = NodeW + 1 + CntW;
  localparam int unsigned OutDataW = ((OutRawW + 7) / 8) * 8;

  typedef enum logic [ModeW-1:0] {
    MODE_CLEAR    = 3'd0,
    MODE_ADD      = 3'd1,
    MODE_REVERSE  = 3'd2,
    MODE_READ_NODE = 3'd3,
    MODE_READ_POS = 3'd4,
    MODE_VISITED  = 3'd5,
    MODE_EDGE     = 3'd6
  } mode_e;

  // Access request from the sequencer to the two memories.
  typedef struct packed {
    logic             tour_we;
    logic [NodeW-1:0] tour_waddr;
    logic [NodeW-1:0] tour_wdata;
    logic [NodeW-1:0] tour_raddr_a;
    logic [NodeW-1:0] tour_raddr_b;
    logic             info_we;
    logic [NodeW-1:0] info_waddr;
    logic             info_wvis;
    logic [NodeW-1:0] info_wpos;
    logic [NodeW-1:0] info_raddr;
  } store_req_t;

  // Registered read data, valid in the cycle after the addresses.
  typedef struct packed {
    logic [NodeW-1:0] tour_a;
    logic [NodeW-1:0] tour_b;
    logic             info_vis;
    logic [NodeW-1:0] info_pos;
  } store_rsp_t;

endpackage

`default_nettype wire

FILE: hdl/tsr_store.sv
`default_nettype none

module tsr_store #(
  parameter int unsigned DEPTH = tsr_pkg::MaxNodesDef
) (
  input  wire logic                clk_i,
  input  wire tsr_pkg::store_req_t req_i,
  output tsr_pkg::store_rsp_t      rsp_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  // Tour order: node number per tour index. Two read ports for swaps and edge scans.
  logic [tsr_pkg::NodeW-1:0] tour_mem [DEPTH];
  // Per node: visited mark above its tour position.
  logic [tsr_pkg::NodeW:0]   info_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (req_i.tour_we) begin
      tour_mem[req_i.tour_waddr[AW-1:0]] <= req_i.tour_wdata;
    end
    if (req_i.info_we) begin
      info_mem[req_i.info_waddr[AW-1:0]] <= {req_i.info_wvis, req_i.info_wpos};
    end
    rsp_o.tour_a                   <= tour_mem[req_i.tour_raddr_a[AW-1:0]];
    rsp_o.tour_b                   <= tour_mem[req_i.tour_raddr_b[AW-1:0]];
    {rsp_o.info_vis, rsp_o.info_pos} <= info_mem[req_i.info_raddr[AW-1:0]];
  end

endmodule

`default_nettype wire

FILE: hdl/tsr_seq.sv
`default_nettype none

module tsr_seq #(
  parameter int unsigned DEPTH = tsr_pkg::MaxNodesDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [tsr_pkg::CntW-1:0]      n_i,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [tsr_pkg::InDataW-1:0]   s_tdata,
  input  wire logic [tsr_pkg::ModeW-1:0]     s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [tsr_pkg::OutDataW-1:0]       m_tdata,
  output tsr_pkg::store_req_t                req_o,
  input  wire tsr_pkg::store_rsp_t           rsp_i
);

  localparam int unsigned NW = tsr_pkg::NodeW;
  localparam int unsigned CW = tsr_pkg::CntW;
  localparam logic [CW-1:0] DepthLast = CW'(DEPTH - 1);

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_ADD,
    S_RD,
    S_REV_INIT,
    S_REV_RD,
    S_REV_W1,
    S_REV_W2,
    S_EDGE,
    S_FIN
  } state_e;

  state_e          state_q, state_d;
  tsr_pkg::mode_e  mode_q, mode_d;
  logic [NW-1:0]   na_q, na_d, nb_q, nb_d, fi_q, fi_d, li_q, li_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [CW-1:0]   left_q, left_d, right_q, right_d, cnt_q, cnt_d;
  logic [CW-1:0]   filled_q, filled_d;
  logic [NW-1:0]   tmp_q, tmp_d;
  logic            pend_q, pend_d;
  logic            clr_out_q, clr_out_d;
  logic [NW-1:0]   res_value_q, res_value_d;
  logic            res_flag_q, res_flag_d;
  logic            m_valid_q, m_valid_d;
  logic [NW-1:0]   out_value_q, out_value_d;
  logic            out_flag_q, out_flag_d;
  logic [CW-1:0]   out_len_q, out_len_d;

  logic            accept;
  logic [NW-1:0]   in_na, in_nb, in_fi, in_li;
  logic [CW+1:0]   seg_raw, seg_mod, two_n;
  logic [CW-1:0]   left_nx, right_nx;

  assign in_na = s_tdata[NW-1:0];
  assign in_nb = s_tdata[2*NW-1:NW];
  assign in_fi = s_tdata[3*NW-1:2*NW];
  assign in_li = s_tdata[4*NW-1:3*NW];

  assign s_tready = (state_q == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  assign m_tvalid = m_valid_q;
  assign m_tdata  = {(tsr_pkg::OutDataW - tsr_pkg::OutRawW)'(0), out_len_q, out_flag_q,
                     out_value_q};

  // Segment length modulo n, before halving; the raw sum lies between 2 and 2n.
  assign two_n   = {1'b0, n_i, 1'b0};
  assign seg_raw = (CW+2)'(li_q) + (CW+2)'(1) + (CW+2)'(n_i) - (CW+2)'(fi_q);
  always_comb begin
    if (seg_raw >= two_n) begin
      seg_mod = seg_raw - two_n;
    end else if (seg_raw >= (CW+2)'(n_i)) begin
      seg_mod = seg_raw - (CW+2)'(n_i);
    end else begin
      seg_mod = seg_raw;
    end
  end

  assign left_nx  = (left_q + CW'(1) == n_i) ? '0 : left_q + CW'(1);
  assign right_nx = (right_q == '0) ? n_i - CW'(1) : right_q - CW'(1);

  // Memory access for the current state.
  always_comb begin
    req_o              = '0;
    req_o.tour_raddr_a = in_fi;
    req_o.info_raddr   = in_na;
    case (state_q)
      S_CLR: begin
        req_o.info_we    = 1'b1;
        req_o.info_waddr = idx_q[NW-1:0];
      end
      S_ADD: begin
        if (filled_q < n_i && CW'(na_q) < n_i) begin
          req_o.tour_we    = 1'b1;
          req_o.tour_waddr = filled_q[NW-1:0];
          req_o.tour_wdata = na_q;
          req_o.info_we    = 1'b1;
          req_o.info_waddr = na_q;
          req_o.info_wvis  = 1'b1;
          req_o.info_wpos  = filled_q[NW-1:0];
        end
      end
      S_REV_RD: begin
        req_o.tour_raddr_a = left_q[NW-1:0];
        req_o.tour_raddr_b = right_q[NW-1:0];
      end
      S_REV_W1: begin
        req_o.tour_we    = 1'b1;
        req_o.tour_waddr = left_q[NW-1:0];
        req_o.tour_wdata = rsp_i.tour_b;
        req_o.info_we    = 1'b1;
        req_o.info_waddr = rsp_i.tour_b;
        req_o.info_wvis  = 1'b1;
        req_o.info_wpos  = left_q[NW-1:0];
      end
      S_REV_W2: begin
        req_o.tour_we    = 1'b1;
        req_o.tour_waddr = right_q[NW-1:0];
        req_o.tour_wdata = tmp_q;
        req_o.info_we    = 1'b1;
        req_o.info_waddr = tmp_q;
        req_o.info_wvis  = 1'b1;
        req_o.info_wpos  = right_q[NW-1:0];
      end
      S_EDGE: begin
        req_o.tour_raddr_a = NW'(idx_q - CW'(1));
        req_o.tour_raddr_b = idx_q[NW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    na_d        = na_q;
    nb_d        = nb_q;
    fi_d        = fi_q;
    li_d        = li_q;
    idx_d       = idx_q;
    left_d      = left_q;
    right_d     = right_q;
    cnt_d       = cnt_q;
    filled_d    = filled_q;
    tmp_d       = tmp_q;
    pend_d      = pend_q;
    clr_out_d   = clr_out_q;
    res_value_d = res_value_q;
    res_flag_d  = res_flag_q;
    m_valid_d   = m_valid_q && !m_tready;
    out_value_d = out_value_q;
    out_flag_d  = out_flag_q;
    out_len_d   = out_len_q;

    case (state_q)
      S_CLR: begin
        idx_d = idx_q + CW'(1);
        if (idx_q == DepthLast) begin
          if (clr_out_q) begin
            res_flag_d = 1'b1;
            state_d    = S_FIN;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (accept) begin
          mode_d      = tsr_pkg::mode_e'(s_tuser);
          na_d        = in_na;
          nb_d        = in_nb;
          fi_d        = in_fi;
          li_d        = in_li;
          res_value_d = '0;
          res_flag_d  = 1'b0;
          idx_d       = CW'(1);
          pend_d      = 1'b0;
          case (tsr_pkg::mode_e'(s_tuser))
            tsr_pkg::MODE_CLEAR: begin
              idx_d     = '0;
              filled_d  = '0;
              clr_out_d = 1'b1;
              state_d   = S_CLR;
            end
            tsr_pkg::MODE_ADD:       state_d = S_ADD;
            tsr_pkg::MODE_REVERSE:   state_d = S_REV_INIT;
            tsr_pkg::MODE_READ_NODE,
            tsr_pkg::MODE_READ_POS,
            tsr_pkg::MODE_VISITED:   state_d = S_RD;
            tsr_pkg::MODE_EDGE:      state_d = S_EDGE;
            default:                 state_d = S_FIN;
          endcase
        end
      end
      S_ADD: begin
        if (filled_q < n_i && CW'(na_q) < n_i) begin
          filled_d   = filled_q + CW'(1);
          res_flag_d = 1'b1;
        end
        state_d = S_FIN;
      end
      S_RD: begin
        case (mode_q)
          tsr_pkg::MODE_READ_NODE: begin
            if (CW'(fi_q) < filled_q) begin
              res_value_d = rsp_i.tour_a;
              res_flag_d  = 1'b1;
            end
          end
          tsr_pkg::MODE_READ_POS: begin
            if (CW'(na_q) < n_i) begin
              res_value_d = rsp_i.info_pos;
              res_flag_d  = 1'b1;
            end
          end
          default: begin
            res_flag_d = (CW'(na_q) < n_i) && rsp_i.info_vis;
          end
        endcase
        state_d = S_FIN;
      end
      S_REV_INIT: begin
        left_d  = CW'(fi_q);
        right_d = CW'(li_q);
        cnt_d   = seg_mod[CW:1];
        state_d = S_FIN;
        if (filled_q == n_i && CW'(fi_q) < n_i && CW'(li_q) < n_i) begin
          res_flag_d = 1'b1;
          if (seg_mod[CW:1] != '0) begin
            state_d = S_REV_RD;
          end
        end
      end
      S_REV_RD: state_d = S_REV_W1;
      S_REV_W1: begin
        tmp_d   = rsp_i.tour_a;
        state_d = S_REV_W2;
      end
      S_REV_W2: begin
        left_d  = left_nx;
        right_d = right_nx;
        cnt_d   = cnt_q - CW'(1);
        state_d = (cnt_q == CW'(1)) ? S_FIN : S_REV_RD;
      end
      S_EDGE: begin
        // Check the pair read last cycle while the next pair is being read.
        if (pend_q && rsp_i.tour_a == na_q && rsp_i.tour_b == nb_q) begin
          res_flag_d = 1'b1;
          state_d    = S_FIN;
        end else if (idx_q < filled_q) begin
          pend_d = 1'b1;
          idx_d  = idx_q + CW'(1);
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!m_valid_q || m_tready) begin
          m_valid_d   = 1'b1;
          out_value_d = res_value_q;
          out_flag_d  = res_flag_q;
          out_len_d   = filled_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      mode_q      <= tsr_pkg::MODE_CLEAR;
      na_q        <= '0;
      nb_q        <= '0;
      fi_q        <= '0;
      li_q        <= '0;
      idx_q       <= '0;
      left_q      <= '0;
      right_q     <= '0;
      cnt_q       <= '0;
      filled_q    <= '0;
      tmp_q       <= '0;
      pend_q      <= 1'b0;
      clr_out_q   <= 1'b0;
      res_value_q <= '0;
      res_flag_q  <= 1'b0;
      m_valid_q   <= 1'b0;
      out_value_q <= '0;
      out_flag_q  <= 1'b0;
      out_len_q   <= '0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      na_q        <= na_d;
      nb_q        <= nb_d;
      fi_q        <= fi_d;
      li_q        <= li_d;
      idx_q       <= idx_d;
      left_q      <= left_d;
      right_q     <= right_d;
      cnt_q       <= cnt_d;
      filled_q    <= filled_d;
      tmp_q       <= tmp_d;
      pend_q      <= pend_d;
      clr_out_q   <= clr_out_d;
      res_value_q <= res_value_d;
      res_flag_q  <= res_flag_d;
      m_valid_q   <= m_valid_d;
      out_value_q <= out_value_d;
      out_flag_q  <= out_flag_d;
      out_len_q   <= out_len_d;
    end
  end

  a_filled_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= CW'(DEPTH))
    else $error("tour fill count beyond storage depth");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != S_IDLE)
    else $error("sequencer stayed idle after taking a beat");

  a_swap_pair_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_REV_RD |-> left_q != right_q && cnt_q != '0)
    else $error("reversal swap on a single entry or with no swaps left");

  a_tour_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_o.tour_we |-> state_q == S_ADD || state_q == S_REV_W1 || state_q == S_REV_W2)
    else $error("tour store written outside add or reversal");

  a_fill_only_add_or_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q != $past(filled_q) |-> $past(state_q) == S_ADD || $past(state_q) == S_IDLE)
    else $error("fill count changed outside add or clear");

endmodule

`default_nettype wire

FILE: hdl/tour_store_with_segment_reversal_top.sv
`default_nettype none

// Channel  Dir  Handshake          Payload
// s        in   s_tvalid/s_tready  tdata: first_node, second_node, first_index, last_index
//                                  tuser: mode
// m        out  m_tvalid/m_tready  tdata: result_value, result_flag, tour_length
// cfg      in   cfg_valid_i/o      node_count (11 bits)
//
// One beat is taken at a time. A reversal reads both entries of each swap and
// then writes them back one after the other on the single tour write port, an
// edge test scans the tour pair by pair, and clear sweeps the position/visited
// memory one entry per cycle, over D = min(MAX_NODES, 1024) entries, the store
// depth. After reset the same sweep runs before the first beat is taken, and
// configuration writes are taken at any time.
// A finished result waits in the output register while the next beat is accepted.

module tour_store_with_segment_reversal_top #(
  parameter int unsigned MAX_NODES = tsr_pkg::MaxNodesDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // [9:0] first_node, [19:10] second_node, [29:20] first_index, [39:30] last_index
  input  wire logic [tsr_pkg::InDataW-1:0]  s_tdata,
  // [2:0] mode
  input  wire logic [tsr_pkg::ModeW-1:0]    s_tuser,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  // [9:0] result_value, [10] result_flag, [21:11] tour_length, [23:22] zero
  output logic [tsr_pkg::OutDataW-1:0]      m_tdata,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [tsr_pkg::CntW-1:0]     cfg_data_i
);

  localparam int unsigned DEPTH = (MAX_NODES < tsr_pkg::NodeCap) ? MAX_NODES
                                                                 : tsr_pkg::NodeCap;
  localparam int unsigned CW = tsr_pkg::CntW;
  localparam logic [CW-1:0] NodeCapEff = CW'(DEPTH);
  localparam logic [CW-1:0] NodeMin    = CW'(2);

  logic [CW-1:0]       node_count_q, node_count_d;
  logic [CW-1:0]       n_eff;
  tsr_pkg::store_req_t req;
  tsr_pkg::store_rsp_t rsp;

  assign cfg_ready_o  = 1'b1;
  assign node_count_d = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : node_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= tsr_pkg::NodeCountRst;
    end else begin
      node_count_q <= node_count_d;
    end
  end

  // Node count in use, clamped between 2 and what the store can hold.
  always_comb begin
    if (node_count_q < NodeMin) begin
      n_eff = NodeMin;
    end else if (node_count_q > NodeCapEff) begin
      n_eff = NodeCapEff;
    end else begin
      n_eff = node_count_q;
    end
  end

  tsr_seq #(
    .DEPTH(DEPTH)
  ) u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .n_i     (n_eff),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .req_o   (req),
    .rsp_i   (rsp)
  );

  tsr_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i(clk_i),
    .req_i(req),
    .rsp_o(rsp)
  );

endmodule

`default_nettype wire
